[sv/hsrp_pkg.sv]
// shared types and constants of the six-axis report parser
package hsrp_pkg;

  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_MAX = 4'd15;
  localparam logic [POS_W-1:0] AXIS_MIN_POS = 4'd6;
  localparam logic [POS_W-1:0] APPEND_ID_POS = 4'd7;
  localparam logic [POS_W-1:0] APPEND_MIN_POS = 4'd13;
  localparam logic [POS_W-1:0] BTN_LAST_POS = 4'd8;

  localparam logic [7:0] ID_TRANS = 8'h01;
  localparam logic [7:0] ID_ROT = 8'h02;
  localparam logic [7:0] ID_BUTTONS = 8'h03;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_TRANS = 2'd1;
  localparam logic [1:0] KIND_ROT = 2'd2;
  localparam logic [1:0] KIND_BUTTONS = 2'd3;

  typedef struct packed {
    logic        pend_we;
    logic [2:0]  pend_idx;
    logic [15:0] word;
    logic        btn_we;
    logic [2:0]  btn_idx;
    logic [7:0]  btn_byte;
    logic        last;
    logic        commit_prim;
    logic        prim_rot;
    logic        commit_other;
    logic        recognized;
  } cmd_t;

endpackage

[sv/hsrp_in_if.sv]
// byte input channel
interface hsrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last_of_report;

  modport source (output valid, output report_byte, output last_of_report, input ready);
  modport sink (input valid, input report_byte, input last_of_report, output ready);
endinterface

[sv/hsrp_out_if.sv]
// result channel
interface hsrp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_tx;
  logic signed [15:0] axis_ty;
  logic signed [15:0] axis_tz;
  logic signed [15:0] axis_rx;
  logic signed [15:0] axis_ry;
  logic signed [15:0] axis_rz;
  logic [31:0]        button_map;
  logic               report_updated;

  modport source (output valid, output axis_tx, output axis_ty, output axis_tz,
                  output axis_rx, output axis_ry, output axis_rz, output button_map,
                  output report_updated, input ready);
  modport sink (input valid, input axis_tx, input axis_ty, input axis_tz,
                input axis_rx, input axis_ry, input axis_rz, input button_map,
                input report_updated, output ready);
endinterface

[sv/hsrp_front.sv]
// front end: tracks byte position and report kind, turns bytes into commands
module hsrp_front
  import hsrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  hsrp_in_if.sink  in_if,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             match_r, match_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [1:0]       kind_cur;
  logic             is_axis;
  logic             accept;
  logic [7:0]       b;

  assign b = in_if.report_byte;
  assign in_if.ready = !q_full;
  assign accept = in_if.valid && !q_full;

  always_comb begin
    if (pos_r != '0) begin
      kind_cur = kind_r;
    end else if (b == ID_TRANS) begin
      kind_cur = KIND_TRANS;
    end else if (b == ID_ROT) begin
      kind_cur = KIND_ROT;
    end else if (b == ID_BUTTONS) begin
      kind_cur = KIND_BUTTONS;
    end else begin
      kind_cur = KIND_UNKNOWN;
    end
    is_axis = (kind_cur == KIND_TRANS) || (kind_cur == KIND_ROT);
  end

  always_comb begin
    q_cmd = '0;
    q_cmd.word = {b, low_r};
    q_cmd.btn_byte = b;
    low_nxt = low_r;
    match_nxt = (pos_r == '0) ? 1'b0 : match_r;
    if (pos_r != '0 && is_axis) begin
      if (pos_r <= AXIS_MIN_POS) begin
        if (pos_r[0]) begin
          low_nxt = b;
        end else begin
          q_cmd.pend_we = 1'b1;
          q_cmd.pend_idx = 3'(pos_r[3:1] - 3'd1);
        end
      end else if (pos_r == APPEND_ID_POS) begin
        match_nxt = (kind_cur == KIND_TRANS) ? (b == ID_ROT) : (b == ID_TRANS);
      end else if (pos_r <= APPEND_MIN_POS) begin
        if (!pos_r[0]) begin
          low_nxt = b;
        end else begin
          q_cmd.pend_we = 1'b1;
          q_cmd.pend_idx = 3'(pos_r[3:1] - 3'd1);
        end
      end
    end else if (pos_r != '0 && kind_cur == KIND_BUTTONS && pos_r <= BTN_LAST_POS) begin
      q_cmd.btn_we = 1'b1;
      q_cmd.btn_idx = 3'(pos_r - 4'd1);
    end
    q_cmd.last = in_if.last_of_report;
    q_cmd.prim_rot = (kind_cur == KIND_ROT);
    q_cmd.commit_prim = in_if.last_of_report && is_axis && (pos_r >= AXIS_MIN_POS);
    q_cmd.commit_other = q_cmd.commit_prim && (pos_r >= APPEND_MIN_POS) && match_r;
    q_cmd.recognized = q_cmd.commit_prim ||
                       (kind_cur == KIND_BUTTONS && pos_r != '0);
    if (!accept) begin
      match_nxt = match_r;
      low_nxt = low_r;
    end else if (in_if.last_of_report) begin
      match_nxt = 1'b0;
    end
  end

  assign q_push = accept && (q_cmd.pend_we || q_cmd.btn_we || q_cmd.last);

  always_comb begin
    pos_nxt = pos_r;
    kind_nxt = kind_r;
    if (accept) begin
      if (in_if.last_of_report) begin
        pos_nxt = '0;
        kind_nxt = KIND_UNKNOWN;
      end else begin
        kind_nxt = kind_cur;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      kind_r <= KIND_UNKNOWN;
      match_r <= 1'b0;
      low_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      kind_r <= kind_nxt;
      match_r <= match_nxt;
      low_r <= low_nxt;
    end
  end

endmodule

[sv/hsrp_queue.sv]
// two-entry command queue between front and back
module hsrp_queue
  import hsrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t       ent_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head = ent_r[rd_r];

  always_comb begin
    wr_nxt = push ? !wr_r : wr_r;
    rd_nxt = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/hsrp_back.sv]
// back end: pending words, axis and button state, result register
module hsrp_back
  import hsrp_pkg::*;
#(
  parameter int NUM_BUTTONS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_avail,
  input  cmd_t       q_head,
  output logic       q_pop,
  hsrp_out_if.source out_if
);

  logic [15:0]            pend_r [6];
  logic [15:0]            pend_nxt [6];
  logic [15:0]            axis_r [6];
  logic [15:0]            axis_nxt [6];
  logic [NUM_BUTTONS-1:0] btn_r, btn_nxt;
  logic [63:0]            btn_ext;
  logic                   ov_r, ov_nxt;
  logic [15:0]            oax_r [6];
  logic [31:0]            obtn_r;
  logic                   oupd_r;

  assign q_pop = q_avail && (!q_head.last || !ov_r || out_if.ready);
  assign btn_ext = 64'(btn_nxt);

  always_comb begin
    pend_nxt = pend_r;
    axis_nxt = axis_r;
    btn_nxt = btn_r;
    for (int i = 0; i < 6; i++) begin
      if (q_head.pend_we && q_head.pend_idx == 3'(i)) begin
        pend_nxt[i] = q_head.word;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (q_head.commit_prim) begin
        if (q_head.prim_rot) begin
          axis_nxt[3+i] = pend_nxt[i];
        end else begin
          axis_nxt[i] = pend_nxt[i];
        end
      end
      if (q_head.commit_other) begin
        if (q_head.prim_rot) begin
          axis_nxt[i] = pend_nxt[3+i];
        end else begin
          axis_nxt[3+i] = pend_nxt[3+i];
        end
      end
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (q_head.btn_we && q_head.btn_idx == 3'(i / 8)) begin
        btn_nxt[i] = q_head.btn_byte[i % 8];
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (q_pop && q_head.last) begin
      ov_nxt = 1'b1;
    end else if (out_if.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_r <= pend_nxt;
    end
    if (q_pop && q_head.last) begin
      oax_r <= axis_nxt;
      obtn_r <= btn_ext[31:0];
      oupd_r <= q_head.recognized;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      btn_r <= '0;
      for (int i = 0; i < 6; i++) begin
        axis_r[i] <= '0;
      end
    end else begin
      ov_r <= ov_nxt;
      if (q_pop) begin
        btn_r <= btn_nxt;
        axis_r <= axis_nxt;
      end
    end
  end

  assign out_if.valid = ov_r;
  assign out_if.axis_tx = oax_r[0];
  assign out_if.axis_ty = oax_r[1];
  assign out_if.axis_tz = oax_r[2];
  assign out_if.axis_rx = oax_r[3];
  assign out_if.axis_ry = oax_r[4];
  assign out_if.axis_rz = oax_r[5];
  assign out_if.button_map = obtn_r;
  assign out_if.report_updated = oupd_r;

endmodule

[sv/hid_six_axis_report_parser.sv]
// Six-axis HID input report parser. Takes one report byte per cycle on in_if, with
// last_of_report marking the final byte of a report, and gives one result on out_if for
// each report: all six held axis values, the low 32 button bits and a flag that says
// whether the report was recognized and long enough. A byte is accepted every cycle
// as long as the result side keeps up; the front end classifies each byte and sends a
// command through a two-entry queue to the back end, which holds the axis and button
// state and a result register, so a waiting result stalls the input only once the
// queue has filled. The last byte's command passes the queue, then the result register.
module hid_six_axis_report_parser
  import hsrp_pkg::*;
#(
  parameter int NUM_BUTTONS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  hsrp_in_if.sink    in_if,
  hsrp_out_if.source out_if
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_avail;
  cmd_t q_cmd;
  cmd_t q_head;

  hsrp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  hsrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  hsrp_back #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_avail (q_avail),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
